// File: rtl/core/pdpb_pkg.sv
// ----------------------------------------------------------------------------
// pdpb_pkg: shared definitions for the per-destination pause buffer
// Defaults, item codes and status codes.
// ----------------------------------------------------------------------------
package pdpb_pkg;

	localparam int NUM_DESTS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TX_DEPTH_DEF    = 64;

	localparam int BYTES_W = 25;
	localparam int HANDLE_W = 16;
	localparam int LEN_W = 16;
	localparam int ENTRY_W = HANDLE_W + LEN_W;

	typedef enum logic [1:0] {
		FUNC_DATA = 2'd0,
		FUNC_CTRL = 2'd1,
		FUNC_TICK = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CODE_RESUME = 2'd0,
		CODE_PAUSE  = 2'd1
	} code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_Q_FULL   = 2'd1,
		ST_TBL_FULL = 2'd2,
		ST_BAD_CODE = 2'd3
	} status_t;

endpackage

// File: rtl/core/pdpb_ram.sv
// ----------------------------------------------------------------------------
// pdpb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pdpb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/per_destination_pause_buffer_core.sv
// ----------------------------------------------------------------------------
// per_destination_pause_buffer_core: packet buffer with per-destination pause
//
// Input channel (in_valid/in_stall) carries one item: a data packet, a pause
// or resume control, or a transmit tick. Output channel (out_valid/out_stall)
// returns exactly one result item per input item.
// The destination table is searched by one shared tag comparator, one entry a
// cycle, for each packet and each control item with a valid code; ticks skip it.
// A resume then moves the queue through the one transmit FIFO write
// port, one queued packet at a time (queue RAM read, then FIFO write).
// One item is in work at a time; in_stall is high from acceptance until its
// result is taken. While out_stall is high the result holds and no new item
// is taken. Reset clears the table, queue counts, FIFO pointers and the byte
// total at once; the queue and FIFO memories are not cleared and are only
// read at written places.
// ----------------------------------------------------------------------------
module per_destination_pause_buffer_core #(
	parameter int NUM_DESTS   = pdpb_pkg::NUM_DESTS_DEF,
	parameter int QUEUE_DEPTH = pdpb_pkg::QUEUE_DEPTH_DEF,
	parameter int TX_DEPTH    = pdpb_pkg::TX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] dest_addr,
	input  logic [15:0] pkt_handle,
	input  logic [15:0] pkt_bytes,
	input  logic [1:0]  pause_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [15:0] tx_handle,
	output logic [15:0] tx_bytes,
	output logic [24:0] held_bytes,
	output logic [1:0]  status
);

	localparam int DW  = (NUM_DESTS > 1) ? $clog2(NUM_DESTS) : 1;
	localparam int DCW = $clog2(NUM_DESTS + 1);
	localparam int QW  = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW  = $clog2(TX_DEPTH);
	localparam int TCW = $clog2(TX_DEPTH + 1);
	localparam int HW  = DW + QW;
	localparam int EW  = pdpb_pkg::ENTRY_W;
	localparam int BW  = pdpb_pkg::BYTES_W;
	localparam logic [BW-1:0] BYTE_MAX = {BW{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_APPLY, S_DRAIN_RD, S_DRAIN_WR, S_TICK_RD, S_DONE
	} state_t;

	state_t state_q;

	logic [31:0]    tag_q [NUM_DESTS];
	logic [NUM_DESTS-1:0] vld_q, paused_q;
	logic [QCW-1:0] cnt_q [NUM_DESTS];
	logic [TW-1:0]  head_q, tail_q;
	logic [TCW-1:0] txcnt_q;
	logic [BW-1:0]  total_q;

	logic [1:0]  func_q, code_q;
	logic [31:0] addr_q;
	logic [EW-1:0] pkt_q;
	logic [DCW-1:0] idx_q;
	logic        hit_q, free_found_q;
	logic [DW-1:0] hit_d_q, free_d_q, d_q;
	logic [QCW-1:0] k_q;

	// held RAM
	logic          hq_we;
	logic [HW-1:0] hq_waddr, hq_raddr;
	logic [EW-1:0] hq_rdata;
	// tx RAM
	logic          tx_we;
	logic [TW-1:0] tx_waddr;
	logic [EW-1:0] tx_wdata, tx_rdata;

	pdpb_ram #(.WIDTH(EW), .DEPTH(1 << HW)) u_held (
		.clk(clk), .we(hq_we), .waddr(hq_waddr), .wdata(pkt_q),
		.raddr(hq_raddr), .rdata(hq_rdata)
	);

	pdpb_ram #(.WIDTH(EW), .DEPTH(TX_DEPTH)) u_tx (
		.clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(tx_wdata),
		.raddr(head_q), .rdata(tx_rdata)
	);

	// shared tag comparator
	logic [DW-1:0] scan_d;
	logic          tag_eq;
	assign scan_d = idx_q[DW-1:0];
	assign tag_eq = vld_q[scan_d] && (tag_q[scan_d] == addr_q);

	logic [QCW-1:0] cur_cnt;
	assign cur_cnt = cnt_q[d_q];

	logic apply_data_q_ok, apply_push;
	assign apply_data_q_ok = cur_cnt < QCW'(QUEUE_DEPTH);
	assign apply_push = txcnt_q < TCW'(TX_DEPTH);

	assign hq_we    = (state_q == S_APPLY) && (func_q == pdpb_pkg::FUNC_DATA)
		&& paused_q[d_q] && apply_data_q_ok;
	assign hq_waddr = {d_q, cur_cnt[QW-1:0]};
	assign hq_raddr = {d_q, k_q[QW-1:0]};

	always_comb begin
		tx_we = 1'b0;
		tx_wdata = pkt_q;
		if (state_q == S_APPLY && func_q == pdpb_pkg::FUNC_DATA && !paused_q[d_q]
			&& apply_push) begin
			tx_we = 1'b1;
		end else if (state_q == S_DRAIN_WR && apply_push) begin
			tx_we = 1'b1;
			tx_wdata = hq_rdata;
		end
	end
	assign tx_waddr = tail_q;

	function automatic logic [BW-1:0] add_sat(logic [BW-1:0] a, logic [15:0] b);
		logic [BW:0] s;
		s = {1'b0, a} + (BW+1)'(b);
		return s[BW] ? BYTE_MAX : s[BW-1:0];
	endfunction

	function automatic logic [BW-1:0] sub_floor(logic [BW-1:0] a, logic [15:0] b);
		return (BW'(b) > a) ? '0 : a - BW'(b);
	endfunction

	function automatic logic [TW-1:0] wrap_inc(logic [TW-1:0] p);
		return ({1'b0, p} + (TW+1)'(1) >= (TW+1)'(TX_DEPTH)) ? '0 : p + TW'(1);
	endfunction

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			paused_q <= '0;
			for (int i = 0; i < NUM_DESTS; i++) begin
				tag_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			head_q <= '0;
			tail_q <= '0;
			txcnt_q <= '0;
			total_q <= '0;
			out_valid <= 1'b0;
			tx_valid <= 1'b0;
			tx_handle <= '0;
			tx_bytes <= '0;
			held_bytes <= '0;
			status <= pdpb_pkg::ST_OK;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			hit_d_q <= '0;
			free_d_q <= '0;
			d_q <= '0;
			k_q <= '0;
		end else begin
			if (tx_we) begin
				tail_q <= wrap_inc(tail_q);
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						addr_q <= dest_addr;
						pkt_q <= {pkt_handle, pkt_bytes};
						code_q <= pause_code;
						idx_q <= '0;
						hit_q <= 1'b0;
						free_found_q <= 1'b0;
						tx_valid <= 1'b0;
						tx_handle <= '0;
						tx_bytes <= '0;
						if (func == pdpb_pkg::FUNC_CTRL
							&& pause_code > pdpb_pkg::CODE_PAUSE) begin
							status <= pdpb_pkg::ST_BAD_CODE;
						end else begin
							status <= pdpb_pkg::ST_OK;
						end
						if (func == pdpb_pkg::FUNC_DATA) begin
							state_q <= S_SCAN;
						end else if (func == pdpb_pkg::FUNC_CTRL) begin
							if (pause_code > pdpb_pkg::CODE_PAUSE) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (func == pdpb_pkg::FUNC_TICK
							&& txcnt_q != '0) begin
							state_q <= S_TICK_RD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (!hit_q && tag_eq) begin
						hit_q <= 1'b1;
						hit_d_q <= scan_d;
					end
					if (!free_found_q && !vld_q[scan_d]) begin
						free_found_q <= 1'b1;
						free_d_q <= scan_d;
					end
					if (idx_q == DCW'(NUM_DESTS - 1)) begin
						if (hit_q || tag_eq) begin
							state_q <= S_APPLY;
							d_q <= hit_q ? hit_d_q : scan_d;
						end else if (free_found_q || !vld_q[scan_d]) begin
							state_q <= S_APPLY;
							d_q <= free_found_q ? free_d_q : scan_d;
							vld_q[free_found_q ? free_d_q : scan_d] <= 1'b1;
							paused_q[free_found_q ? free_d_q : scan_d] <= 1'b1;
							tag_q[free_found_q ? free_d_q : scan_d] <= addr_q;
							cnt_q[free_found_q ? free_d_q : scan_d] <= '0;
						end else begin
							status <= pdpb_pkg::ST_TBL_FULL;
							state_q <= S_DONE;
						end
					end
					idx_q <= idx_q + DCW'(1);
				end
				S_APPLY: begin
					if (func_q == pdpb_pkg::FUNC_DATA) begin
						state_q <= S_DONE;
						if (paused_q[d_q]) begin
							if (apply_data_q_ok) begin
								cnt_q[d_q] <= cur_cnt + QCW'(1);
								total_q <= add_sat(total_q, pkt_q[15:0]);
							end else begin
								status <= pdpb_pkg::ST_Q_FULL;
							end
						end else if (apply_push) begin
							txcnt_q <= txcnt_q + TCW'(1);
							total_q <= add_sat(total_q, pkt_q[15:0]);
						end else begin
							status <= pdpb_pkg::ST_Q_FULL;
						end
					end else if (code_q == pdpb_pkg::CODE_PAUSE) begin
						state_q <= S_DONE;
						paused_q[d_q] <= 1'b1;
					end else begin
						paused_q[d_q] <= 1'b0;
						k_q <= '0;
						if (cur_cnt != '0) begin
							state_q <= S_DRAIN_RD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DRAIN_RD: begin
					state_q <= S_DRAIN_WR;
				end
				S_DRAIN_WR: begin
					if (apply_push) begin
						txcnt_q <= txcnt_q + TCW'(1);
					end else begin
						total_q <= sub_floor(total_q, hq_rdata[15:0]);
						status <= pdpb_pkg::ST_Q_FULL;
					end
					k_q <= k_q + QCW'(1);
					if (k_q + QCW'(1) >= cur_cnt) begin
						cnt_q[d_q] <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DRAIN_RD;
					end
				end
				S_TICK_RD: begin
					tx_valid <= 1'b1;
					tx_handle <= tx_rdata[31:16];
					tx_bytes <= tx_rdata[15:0];
					total_q <= sub_floor(total_q, tx_rdata[15:0]);
					head_q <= wrap_inc(head_q);
					txcnt_q <= txcnt_q - TCW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						held_bytes <= total_q;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		txcnt_q <= TCW'(TX_DEPTH))
		else $error("tx count above depth");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_DONE)
		else $error("result outside done state");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("ready while busy");
	a_tx_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tx_valid) |-> func_q == pdpb_pkg::FUNC_TICK)
		else $error("tx on non tick");

endmodule
